// ----- src/irmt_pkg.sv -----
// irmt_pkg: shared types and constants of the interval range map table
// no dependencies; used by src/interval_range_map_table_top.sv

package irmt_pkg;

  // default geometry
  localparam int TableEntries = 16;
  localparam int KeyWidth     = 32;
  localparam int ValueWidth   = 8;

  // field widths fixed by the interface
  localparam int FuncWidth   = 2;
  localparam int StatusWidth = 2;
  localparam int CountOutW   = 5;

  // operation codes
  typedef enum logic [FuncWidth-1:0] {
    FUNC_LOOKUP = 2'd0,
    FUNC_ASSIGN = 2'd1,
    FUNC_CLEAR  = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  // result status codes
  typedef enum logic [StatusWidth-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RSVD  = 2'd3
  } status_e;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_PRE,
    S_SKIP,
    S_POST,
    S_DONE
  } state_e;

endpackage

// ----- src/interval_range_map_table_top.sv -----
// interval_range_map_table_top: sorted boundary table with lookup, assign and clear
// depends on src/irmt_pkg.sv
//
// Usage: one input channel (in_valid_i / in_stall_o) carries func, key_begin,
// key_end and new_value; one output channel (out_valid_o / out_stall_i) returns
// read_value, status and entry_count, one result per transaction. default_value
// is written through cfg_we_i / cfg_wdata_i while the block is idle.
// Flow: a transaction is taken only in the idle state; the block then works
// on it alone. A lookup and an assign walk the table, one boundary per cycle
// through a single shared key comparator and one table read port; clear,
// no-op and empty assigns go straight to the final state. The new table is
// built in the spare bank and committed by a bank swap.
// The result register decouples the sides: a new transaction is accepted while
// a finished result still waits; a stalled result holds, and the next one waits
// in the final state until the register frees up.
// Reset: the table holds one boundary, key 0 with value 0, default_value is 0;
// no clearing pass is needed.

module interval_range_map_table_top #(
  parameter int TABLE_ENTRIES = irmt_pkg::TableEntries,
  parameter int KEY_WIDTH     = irmt_pkg::KeyWidth,
  parameter int VALUE_WIDTH   = irmt_pkg::ValueWidth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             cfg_we_i,
  input  logic [VALUE_WIDTH-1:0]           cfg_wdata_i,
  // request channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [irmt_pkg::FuncWidth-1:0]   func_i,
  input  logic [KEY_WIDTH-1:0]             key_begin_i,
  input  logic [KEY_WIDTH-1:0]             key_end_i,
  input  logic [VALUE_WIDTH-1:0]           new_value_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [VALUE_WIDTH-1:0]           read_value_o,
  output logic [irmt_pkg::StatusWidth-1:0] status_o,
  output logic [irmt_pkg::CountOutW-1:0]   entry_count_o
);

  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int MW = $clog2(TABLE_ENTRIES + 3);
  localparam logic [CW-1:0] CountMax = CW'(TABLE_ENTRIES);
  localparam logic [MW-1:0] MergeMax = MW'(TABLE_ENTRIES);
  localparam logic [CW-1:0] CountOne = CW'(1);

  // two banks of boundaries, the active one is sel_q
  logic [KEY_WIDTH-1:0]   keys_q [2][TABLE_ENTRIES];
  logic [VALUE_WIDTH-1:0] vals_q [2][TABLE_ENTRIES];

  irmt_pkg::state_e state_q, state_d;
  logic                   sel_q, sel_d;
  logic                   fill_q, fill_d;
  logic [VALUE_WIDTH-1:0] fill_val_q, fill_val_d;
  logic [VALUE_WIDTH-1:0] dflt_q;
  logic [CW-1:0]          count_q, count_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [MW-1:0]          m_q, m_d;
  logic [VALUE_WIDTH-1:0] last_v_q, last_v_d;
  logic [VALUE_WIDTH-1:0] acc_v_q, acc_v_d;
  irmt_pkg::func_e        func_q, func_d;
  irmt_pkg::status_e      stat_q, stat_d;
  logic [KEY_WIDTH-1:0]   kb_q, kb_d, ke_q, ke_d;
  logic [VALUE_WIDTH-1:0] nv_q, nv_d;

  logic                   out_valid_q, out_valid_d;
  logic [VALUE_WIDTH-1:0] out_rv_q, out_rv_d;
  irmt_pkg::status_e      out_st_q, out_st_d;
  logic [CW-1:0]          out_cnt_q, out_cnt_d;

  logic                   in_acc, out_free;
  logic                   rd_ok;
  logic [KEY_WIDTH-1:0]   rd_key, cmp_opnd;
  logic [VALUE_WIDTH-1:0] rd_val;
  logic [KEY_WIDTH:0]     cmp_diff;
  logic                   cmp_lt, cmp_le;
  logic                   emit;
  logic [KEY_WIDTH-1:0]   emit_key;
  logic [VALUE_WIDTH-1:0] emit_val;
  logic                   wr_en;
  logic [CW+irmt_pkg::CountOutW-1:0] cnt_ext;

  assign in_stall_o = (state_q != irmt_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // table read port: entry idx_q of the active bank, a cleared table reads as the fill value
  assign rd_ok  = (idx_q < count_q);
  always_comb begin
    if (fill_q) begin
      rd_key = '0;
      rd_val = fill_val_q;
    end else begin
      rd_key = keys_q[sel_q][idx_q[IW-1:0]];
      rd_val = vals_q[sel_q][idx_q[IW-1:0]];
    end
  end

  // shared key comparator
  assign cmp_opnd = (state_q == irmt_pkg::S_SKIP) ? ke_q : kb_q;
  assign cmp_diff = {1'b0, rd_key} - {1'b0, cmp_opnd};
  assign cmp_lt   = cmp_diff[KEY_WIDTH];
  assign cmp_le   = cmp_lt || (rd_key == cmp_opnd);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      irmt_pkg::S_IDLE: begin
        if (in_acc) begin
          case (irmt_pkg::func_e'(func_i))
            irmt_pkg::FUNC_LOOKUP: state_d = irmt_pkg::S_LOOK;
            irmt_pkg::FUNC_ASSIGN: begin
              state_d = (key_begin_i < key_end_i) ? irmt_pkg::S_PRE : irmt_pkg::S_DONE;
            end
            default: state_d = irmt_pkg::S_DONE;
          endcase
        end
      end
      irmt_pkg::S_LOOK: if (!(rd_ok && cmp_le)) state_d = irmt_pkg::S_DONE;
      irmt_pkg::S_PRE:  if (!(rd_ok && cmp_lt)) state_d = irmt_pkg::S_SKIP;
      irmt_pkg::S_SKIP: if (!(rd_ok && cmp_le)) state_d = irmt_pkg::S_POST;
      irmt_pkg::S_POST: if (!rd_ok) state_d = irmt_pkg::S_DONE;
      irmt_pkg::S_DONE: if (out_free) state_d = irmt_pkg::S_IDLE;
      default: state_d = irmt_pkg::S_IDLE;
    endcase
  end

  // datapath and merge
  always_comb begin
    sel_d       = sel_q;
    fill_d      = fill_q;
    fill_val_d  = fill_val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    m_d         = m_q;
    last_v_d    = last_v_q;
    acc_v_d     = acc_v_q;
    func_d      = func_q;
    stat_d      = stat_q;
    kb_d        = kb_q;
    ke_d        = ke_q;
    nv_d        = nv_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_rv_d    = out_rv_q;
    out_st_d    = out_st_q;
    out_cnt_d   = out_cnt_q;
    emit        = 1'b0;
    emit_key    = rd_key;
    emit_val    = rd_val;
    wr_en       = 1'b0;

    case (state_q)
      // take a transaction
      irmt_pkg::S_IDLE: begin
        if (in_acc) begin
          func_d  = irmt_pkg::func_e'(func_i);
          kb_d    = key_begin_i;
          ke_d    = key_end_i;
          nv_d    = new_value_i;
          idx_d   = '0;
          m_d     = '0;
          acc_v_d = '0;
          stat_d  = irmt_pkg::ST_DONE;
          if (irmt_pkg::func_e'(func_i) == irmt_pkg::FUNC_ASSIGN && !(key_begin_i < key_end_i))
            stat_d = irmt_pkg::ST_EMPTY;
          if (irmt_pkg::func_e'(func_i) == irmt_pkg::FUNC_CLEAR) begin
            fill_d     = 1'b1;
            fill_val_d = dflt_q;
            count_d    = CountOne;
          end
        end
      end
      // walk while the boundary is at or below the key
      irmt_pkg::S_LOOK: begin
        if (rd_ok && cmp_le) begin
          acc_v_d = rd_val;
          idx_d   = idx_q + CountOne;
        end
      end
      // copy boundaries below begin, then insert begin
      irmt_pkg::S_PRE: begin
        emit = 1'b1;
        if (rd_ok && cmp_lt) begin
          acc_v_d = rd_val;
          idx_d   = idx_q + CountOne;
        end else begin
          emit_key = kb_q;
          emit_val = nv_q;
        end
      end
      // drop boundaries inside the interval, then insert end with the restored value
      irmt_pkg::S_SKIP: begin
        if (rd_ok && cmp_le) begin
          acc_v_d = rd_val;
          idx_d   = idx_q + CountOne;
        end else begin
          emit     = 1'b1;
          emit_key = ke_q;
          emit_val = acc_v_q;
        end
      end
      // copy boundaries above end
      irmt_pkg::S_POST: begin
        if (rd_ok) begin
          emit  = 1'b1;
          idx_d = idx_q + CountOne;
        end
      end
      // commit and deliver the result
      irmt_pkg::S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_rv_d    = (func_q == irmt_pkg::FUNC_LOOKUP) ? acc_v_q : '0;
          out_st_d    = stat_q;
          out_cnt_d   = count_q;
          if (func_q == irmt_pkg::FUNC_ASSIGN && stat_q == irmt_pkg::ST_DONE) begin
            if (m_q > MergeMax) begin
              out_st_d = irmt_pkg::ST_FULL;
            end else begin
              sel_d     = !sel_q;
              fill_d    = 1'b0;
              count_d   = m_q[CW-1:0];
              out_cnt_d = m_q[CW-1:0];
            end
          end
        end
      end
      default: ;
    endcase

    // canonical merge: a boundary repeating the previous value is dropped
    if (emit && (m_q == '0 || last_v_q != emit_val)) begin
      wr_en    = (m_q < MergeMax);
      m_d      = m_q + MW'(1);
      last_v_d = emit_val;
    end
  end

  // spare bank write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      keys_q[!sel_q][m_q[IW-1:0]] <= emit_key;
      vals_q[!sel_q][m_q[IW-1:0]] <= emit_val;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= irmt_pkg::S_IDLE;
      sel_q       <= 1'b0;
      fill_q      <= 1'b1;
      fill_val_q  <= '0;
      dflt_q      <= '0;
      count_q     <= CountOne;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sel_q       <= sel_d;
      fill_q      <= fill_d;
      fill_val_q  <= fill_val_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dflt_q <= cfg_wdata_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    m_q       <= m_d;
    last_v_q  <= last_v_d;
    acc_v_q   <= acc_v_d;
    func_q    <= func_d;
    stat_q    <= stat_d;
    kb_q      <= kb_d;
    ke_q      <= ke_d;
    nv_q      <= nv_d;
    out_rv_q  <= out_rv_d;
    out_st_q  <= out_st_d;
    out_cnt_q <= out_cnt_d;
  end

  // outputs
  assign cnt_ext       = {{irmt_pkg::CountOutW{1'b0}}, out_cnt_q};
  assign out_valid_o   = out_valid_q;
  assign read_value_o  = out_rv_q;
  assign status_o      = out_st_q;
  assign entry_count_o = cnt_ext[irmt_pkg::CountOutW-1:0];

`ifndef SYNTHESIS
  // table always holds between one and the full number of boundaries
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 && count_q <= CountMax)
    else $error("boundary count out of range");

  // a cleared table holds exactly one boundary
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q |-> count_q == CountOne)
    else $error("cleared table with more than one boundary");

  // results appear only out of the final state
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == irmt_pkg::S_DONE))
    else $error("result raised outside the final state");

  // the merged count never passes two beyond the table size
  a_merge_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == irmt_pkg::S_POST || state_q == irmt_pkg::S_DONE) |-> m_q <= MergeMax + MW'(2))
    else $error("merge count overran");
`endif

endmodule

// ----- tb/testbench.sv -----
// testbench: self-checking bench for interval_range_map_table_top
// depends on src/irmt_pkg.sv and src/interval_range_map_table_top.sv

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumEntries  = irmt_pkg::TableEntries;
  localparam int KeyWidth    = irmt_pkg::KeyWidth;
  localparam int ValueWidth  = irmt_pkg::ValueWidth;
  localparam int FuncWidth   = irmt_pkg::FuncWidth;
  localparam int StatusWidth = irmt_pkg::StatusWidth;
  localparam int CountOutW   = irmt_pkg::CountOutW;
  localparam int WatchLimit  = 20000;

  // expected result of one transaction
  typedef struct {
    logic [ValueWidth-1:0]  read_value;
    logic [StatusWidth-1:0] status;
    logic [CountOutW-1:0]   entry_count;
  } map_result_t;

  // shadow copy of the boundary table and the expected result queue
  class map_scoreboard;
    logic [KeyWidth-1:0]   bkey[NumEntries];
    logic [ValueWidth-1:0] bval[NumEntries];
    int unsigned           nbound;
    logic [ValueWidth-1:0] fill_value;
    map_result_t           pending[$];
    int unsigned           mismatches;

    function void clear_table(logic [ValueWidth-1:0] v);
      for (int i = 0; i < NumEntries; i++) begin
        bkey[i] = '0;
        bval[i] = '0;
      end
      bval[0] = v;
      nbound = 1;
    endfunction

    function logic [ValueWidth-1:0] value_at(logic [KeyWidth-1:0] k);
      logic [ValueWidth-1:0] v;
      v = bval[0];
      for (int i = 0; i < nbound; i++) begin
        if (bkey[i] <= k) v = bval[i];
        else break;
      end
      return v;
    endfunction

    // rebuild the table with [b,e) set to v, merging equal neighbors
    function irmt_pkg::status_e assign_span(logic [KeyWidth-1:0] b, logic [KeyWidth-1:0] e,
                                            logic [ValueWidth-1:0] v);
      logic [KeyWidth-1:0]   sk[$], mk[$];
      logic [ValueWidth-1:0] sv[$], mv[$];
      logic [ValueWidth-1:0] kept;
      if (b >= e) return irmt_pkg::ST_EMPTY;
      kept = value_at(e);
      for (int i = 0; i < nbound; i++)
        if (bkey[i] < b) begin
          sk.push_back(bkey[i]);
          sv.push_back(bval[i]);
        end
      sk.push_back(b);
      sv.push_back(v);
      sk.push_back(e);
      sv.push_back(kept);
      for (int i = 0; i < nbound; i++)
        if (bkey[i] > e) begin
          sk.push_back(bkey[i]);
          sv.push_back(bval[i]);
        end
      foreach (sk[i]) begin
        if (mv.size() > 0 && mv[$] == sv[i]) continue;
        mk.push_back(sk[i]);
        mv.push_back(sv[i]);
      end
      if (mk.size() > NumEntries) return irmt_pkg::ST_FULL;
      clear_table('0);
      foreach (mk[i]) begin
        bkey[i] = mk[i];
        bval[i] = mv[i];
      end
      nbound = mk.size();
      return irmt_pkg::ST_DONE;
    endfunction

    function void note_request(irmt_pkg::func_e f, logic [KeyWidth-1:0] kb,
                               logic [KeyWidth-1:0] ke, logic [ValueWidth-1:0] nv);
      map_result_t r;
      r.read_value = '0;
      r.status = irmt_pkg::ST_DONE;
      case (f)
        irmt_pkg::FUNC_LOOKUP: r.read_value = value_at(kb);
        irmt_pkg::FUNC_ASSIGN: r.status = assign_span(kb, ke, nv);
        irmt_pkg::FUNC_CLEAR:  clear_table(fill_value);
        default: ;
      endcase
      r.entry_count = nbound[CountOutW-1:0];
      pending.push_back(r);
    endfunction

    function void check_result(map_result_t got);
      map_result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result rv=%0d st=%0d cnt=%0d",
                   got.read_value, got.status, got.entry_count);
        return;
      end
      want = pending.pop_front();
      if (got.read_value !== want.read_value || got.status !== want.status ||
          got.entry_count !== want.entry_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp rv=%0d st=%0d cnt=%0d, got rv=%0d st=%0d cnt=%0d",
                   want.read_value, want.status, want.entry_count,
                   got.read_value, got.status, got.entry_count);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [ValueWidth-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  logic [FuncWidth-1:0]   func_i = '0;
  logic [KeyWidth-1:0]    key_begin_i = '0;
  logic [KeyWidth-1:0]    key_end_i = '0;
  logic [ValueWidth-1:0]  new_value_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  logic [ValueWidth-1:0]  read_value_o;
  logic [StatusWidth-1:0] status_o;
  logic [CountOutW-1:0]   entry_count_o;

  map_scoreboard sb = new();
  bit            hold_off = 1'b0;
  int unsigned   idle_cycles = 0;

  interval_range_map_table_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // accepted transactions on both channels
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(irmt_pkg::func_e'(func_i), key_begin_i, key_end_i, new_value_i);
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result('{read_value_o, status_o, entry_count_o});
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  // watchdog on lack of progress
  always @(posedge clk_i) begin
    if (idle_cycles > WatchLimit) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stall per transaction, long hold-off on request
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        out_stall_i <= 1'b1;
        for (int i = 0; i < 300; i++) @(posedge clk_i);
        hold_off = 1'b0;
      end
      n = $urandom_range(0, 3);
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
        @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
      out_stall_i <= ($urandom_range(0, 1) == 0);
    end
  end

  // one request transaction, with a random gap beforehand unless no_gap is set
  task automatic send_request(irmt_pkg::func_e f, logic [KeyWidth-1:0] kb,
                              logic [KeyWidth-1:0] ke, logic [ValueWidth-1:0] nv,
                              bit no_gap);
    if (!no_gap) repeat ($urandom_range(0, 3)) @(posedge clk_i);
    in_valid_i  <= 1'b1;
    func_i      <= f;
    key_begin_i <= kb;
    key_end_i   <= ke;
    new_value_i <= nv;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 1'b0;
  endtask

  // wait until every result has arrived and the block settles
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_default(logic [ValueWidth-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.fill_value = v;
  endtask

  // keys drawn mostly from a small set so boundaries collide and merge
  function automatic logic [KeyWidth-1:0] pick_key();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return $urandom_range(0, 40) * 8;
    endcase
  endfunction

  task automatic random_batch(int count, bit burst);
    logic [KeyWidth-1:0] a, b;
    int unsigned r;
    for (int i = 0; i < count; i++) begin
      a = pick_key();
      b = pick_key();
      r = $urandom_range(0, 99);
      if (r < 40)
        send_request(irmt_pkg::FUNC_LOOKUP, a, $urandom, 8'($urandom), burst);
      else if (r < 93)
        send_request(irmt_pkg::FUNC_ASSIGN, (a < b) ? a : b, (a < b) ? b : a,
                     $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 3)),
                     burst);
      else if (r < 96)
        send_request(irmt_pkg::FUNC_ASSIGN, a, b, 8'($urandom), burst);
      else if (r < 98)
        send_request(irmt_pkg::FUNC_CLEAR, $urandom, $urandom, 8'($urandom), burst);
      else
        send_request(irmt_pkg::FUNC_NOP, $urandom, $urandom, 8'($urandom), burst);
    end
  endtask

  // stimulus
  initial begin
    sb.clear_table('0);
    sb.fill_value = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, every operation, empty interval, table overflow
    send_request(irmt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(irmt_pkg::FUNC_ASSIGN, 0, 32'hFFFF_FFFF, 8'hFF, 0);
    send_request(irmt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
    send_request(irmt_pkg::FUNC_LOOKUP, 32'hFFFF_FFFE, 0, 0, 0);
    send_request(irmt_pkg::FUNC_ASSIGN, 5, 5, 8'h12, 0);
    send_request(irmt_pkg::FUNC_ASSIGN, 9, 3, 8'h12, 0);
    send_request(irmt_pkg::FUNC_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 0);
    for (int i = 0; i < 10; i++)
      send_request(irmt_pkg::FUNC_ASSIGN, 10 * i + 1, 10 * i + 5, i[7:0] + 8'd1, 0);
    send_request(irmt_pkg::FUNC_LOOKUP, 23, 0, 0, 0);
    send_request(irmt_pkg::FUNC_ASSIGN, 0, 1, 8'h00, 0);
    send_request(irmt_pkg::FUNC_CLEAR, 0, 0, 0, 0);
    drain();

    // random phases across several defaults
    for (int p = 0; p < 5; p++) begin
      write_default(p == 0 ? 8'hFF : p == 1 ? 8'h00 : 8'($urandom));
      send_request(irmt_pkg::FUNC_CLEAR, 0, 0, 0, 0);
      if (p == 2) begin
        hold_off = 1'b1;
        random_batch(30, 1);
      end
      random_batch(400, 0);
      drain();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
